>>> design/mlef_pkg.sv
// Package for the multi-line event FIFO: sizes, word types and helpers.
// No dependencies; imported by every module of the block.
package mlef_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LINES   = 8;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LINE_W      = $clog2(NUM_LINES);
  localparam int LIMIT_W     = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

  typedef struct packed {
    logic [7:0] line_mask;
    logic       unstack;
  } in_word_t;

  typedef struct packed {
    logic       unstack_ack;
    logic [3:0] served_line;
    logic [4:0] occupancy;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic push_step;
    logic rd;
    logic finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic mask_empty;
    logic out_free;
  } status_t;

endpackage

>>> design/mlef_ctrl.sv
// Sequencer for the multi-line event FIFO: accept, push lines, read head, finish.
// Depends on mlef_pkg.
module mlef_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  mlef_pkg::status_t status,
  output mlef_pkg::cmd_t    cmd
);
  import mlef_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_READ,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_step = 1'b1;
        if (status.mask_empty) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/mlef_dp.sv
// Datapath for the multi-line event FIFO: ring store, head/count, limit, result register.
// Depends on mlef_pkg; driven by mlef_ctrl commands.
module mlef_dp (
  input  logic                clk,
  input  logic                rst,
  input  mlef_pkg::cmd_t      cmd,
  output mlef_pkg::status_t   status,
  input  mlef_pkg::in_word_t  item,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  output logic                result_valid,
  input  logic                result_ready,
  output mlef_pkg::out_word_t result
);
  import mlef_pkg::*;

  logic [LINE_W-1:0]  queue_store [QUEUE_DEPTH];
  logic [ADDR_W-1:0]  head;
  logic [CNT_W-1:0]   count;
  logic [LIMIT_W-1:0] limit;
  logic [NUM_LINES-1:0] mask;
  logic               unstack;
  logic [LINE_W-1:0]  rd_data;

  logic [CNT_W-1:0]   eff_limit;
  logic [LINE_W-1:0]  low_line;
  logic [ADDR_W-1:0]  tail;
  logic               room;
  logic               pop;

  assign eff_limit = (limit > LIMIT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(limit);
  assign room      = count < eff_limit;
  assign tail      = head + count[ADDR_W-1:0];
  assign pop       = unstack && (count != '0);

  // lowest pending line; scan high to low so the lowest set bit wins
  always_comb begin
    low_line = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        low_line = LINE_W'(i);
      end
    end
  end

  assign status.mask_empty = (mask == '0);
  assign status.out_free   = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.push_step && (mask != '0) && room) begin
      queue_store[tail] <= low_line;
    end
    if (cmd.rd) begin
      rd_data <= queue_store[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask    <= item.line_mask[NUM_LINES-1:0];
      unstack <= item.unstack;
    end else if (cmd.push_step && (mask != '0)) begin
      mask[low_line] <= 1'b0;
    end
    if (cmd.finish) begin
      result.unstack_ack <= unstack;
      result.served_line <= pop ? (4'(rd_data) + 4'd1) : 4'd0;
      result.occupancy   <= 5'(count - CNT_W'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      count        <= '0;
      limit        <= LIMIT_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
        head  <= '0;
        count <= '0;
      end else if (cmd.push_step && (mask != '0) && room) begin
        count <= count + CNT_W'(1);
      end else if (cmd.finish && pop) begin
        head  <= head + ADDR_W'(1);
        count <= count - CNT_W'(1);
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/multi_line_event_fifo.sv
// Top level of the multi-line event FIFO: controller plus datapath.
// Depends on mlef_pkg, mlef_ctrl and mlef_dp.
//
//   channel  direction  handshake                    word
//   item     in         item_valid / item_ready      in_word_t  {line_mask, unstack}
//   result   out        result_valid / result_ready  out_word_t {ack, served_line, occupancy}
//   cfg      in         cfg_we (no wait)             queue_limit, 5 bits
//
// One item at a time: an accepted word passes the push, read and finish steps, its result
// word is registered at the finish step, and the next word is taken back in idle. The push
// step is set by the single write port of the ring store (one line per cycle, plus a step
// to see the mask empty) and the read step by its registered read of the head entry.
// Synchronous reset: queue empty, limit 8, no result pending.
// A stalled result holds in the output register; the next item is accepted and
// pushed meanwhile, and waits only at the final step.
module multi_line_event_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mlef_pkg::in_word_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output mlef_pkg::out_word_t result,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);
  import mlef_pkg::*;

  cmd_t    cmd;
  status_t status;

  mlef_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  mlef_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while previous still in work");

  a_serve_needs_ack: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.served_line != 4'd0) |-> result.unstack_ack)
    else $error("line served without unstack");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.served_line <= 4'(NUM_LINES)))
    else $error("served line out of range");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.occupancy <= 5'(QUEUE_DEPTH)))
    else $error("occupancy above depth");

endmodule

>>> tb/tb_multi_line_event_fifo.sv
// Testbench for multi_line_event_fifo: directed and random line-event traffic
// checked word by word against an in-bench ring queue model. Depends on mlef_pkg.
`timescale 1ns / 100ps

module tb_multi_line_event_fifo;
  import mlef_pkg::*;

  localparam int SETTLE_CYCLES = 24;     // longest item (all lines fired), plus margin
  localparam int LONG_HOLD     = 300;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_word_t  item;
  logic      result_valid;
  logic      result_ready;
  out_word_t result;
  logic      cfg_we;
  logic [4:0] cfg_wdata;

  multi_line_event_fifo i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Queue model state
  logic [LINE_W-1:0]  line_ring [QUEUE_DEPTH];
  logic [ADDR_W-1:0]  head_pos;
  int                 held_lines;
  logic [LIMIT_W-1:0] limit_reg;

  out_word_t expected_results [$];
  int        fail_count;
  bit        idle_on;
  bit        long_hold;
  int        stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void clear_event_queue();
    head_pos   = '0;
    held_lines = 0;
  endfunction

  // Push fired lines in ascending order up to the limit, then serve the head.
  function automatic out_word_t advance_event_queue(in_word_t w);
    out_word_t r;
    int        cap;
    cap = (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_reg);
    r   = '0;
    for (int ln = 0; ln < NUM_LINES; ln++) begin
      if (w.line_mask[ln] && held_lines < cap) begin
        line_ring[ADDR_W'(int'(head_pos) + held_lines)] = ln[LINE_W-1:0];
        held_lines++;
      end
    end
    r.unstack_ack = w.unstack;
    if (w.unstack && held_lines > 0) begin
      r.served_line = 4'(line_ring[head_pos]) + 4'd1;
      head_pos      = head_pos + 1'b1;
      held_lines--;
    end
    r.occupancy = 5'(held_lines);
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %p", result);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.unstack_ack !== want.unstack_ack) begin
          $error("unstack_ack: expected %0d, got %0d", want.unstack_ack, result.unstack_ack);
          fail_count++;
        end
        if (result.served_line !== want.served_line) begin
          $error("served_line: expected %0d, got %0d", want.served_line, result.served_line);
          fail_count++;
        end
        if (result.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, result.occupancy);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (long_hold) begin
          stall_left = LONG_HOLD;
          long_hold  = 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 13);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Offer one word; valid is left high so a following word goes out back to back.
  task automatic send_word(input logic [7:0] mask, input logic pop);
    int       gap;
    in_word_t w;
    w.line_mask = mask;
    w.unstack   = pop;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!item_ready);
    expected_results.push_back(advance_event_queue(w));
  endtask

  // Stop offering and wait until every expected word is back and the block is quiet.
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_reg = value;
    clear_event_queue();
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    w.unstack = $urandom_range(0, 9) < 6;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        w.line_mask = '0;
        w.unstack   = 1'b1;
      end
      3, 4, 5: w.line_mask = 8'(1 << $urandom_range(0, NUM_LINES - 1));
      6:       w.line_mask = 8'($urandom & $urandom);
      7:       w.line_mask = 8'($urandom);
      8:       w.line_mask = '0;
      default: w.line_mask = 8'hFF;
    endcase
    return w;
  endfunction

  task automatic send_random(input int count);
    in_word_t w;
    repeat (count) begin
      w = random_word();
      send_word(w.line_mask, w.unstack);
    end
  endtask

  // Empty-queue ack, full mask at the reset limit, same-word push and serve
  task automatic test_directed_basics();
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b1);       // pushed and served in one word
    send_word(8'hFF, 1'b0);       // fills to 8
    send_word(8'hFF, 1'b1);       // all dropped, one served
    send_word(8'h01, 1'b0);
    repeat (9) send_word(8'h00, 1'b1);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b1);
    drain_results();
  endtask

  task automatic test_limit_extremes();
    write_limit(5'd0);            // nothing is ever held
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b0);
    write_limit(5'd31);           // clamps to the ring depth
    repeat (3) send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    write_limit(5'd16);
    send_word(8'hF0, 1'b0);
    write_limit(5'd1);
    send_word(8'h0F, 1'b1);
    send_word(8'h0F, 1'b0);
    send_word(8'h0F, 1'b0);
    drain_results();
  endtask

  task automatic test_limit_write_clears();
    write_limit(5'd12);
    send_word(8'hFF, 1'b0);
    write_limit(5'd12);
    send_word(8'h00, 1'b1);       // queue was emptied by the write
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [4:0] limits [10] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd3, 5'd17, 5'd5, 5'd12,
                                5'd2, 5'd8};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      send_random(70);
      drain_results();            // sender pause mid-phase, state kept
      send_random(70);
    end
  endtask

  task automatic test_backpressure_fill();
    write_limit(5'd16);
    long_hold = 1'b1;
    send_random(80);
    drain_results();
  endtask

  task automatic test_no_idle_stream();
    write_limit(5'd6);
    idle_on = 1'b0;
    send_random(200);
    drain_results();
  endtask

  initial begin
    fail_count   = 0;
    idle_on      = 1'b1;
    long_hold    = 1'b0;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    limit_reg    = LIMIT_RESET;
    clear_event_queue();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_limit_extremes();
    test_limit_write_clears();
    test_random_traffic();
    test_backpressure_fill();
    test_no_idle_stream();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mlef_pkg.sv
design/mlef_ctrl.sv
design/mlef_dp.sv
design/multi_line_event_fifo.sv
tb/tb_multi_line_event_fifo.sv
